### hdl/prs_pkg.sv
// ----------------------------------------------------------------------------
// prs_pkg
// Types and fixed constants shared by the RTT statistics block and its checker.
// ----------------------------------------------------------------------------
package prs_pkg;

  localparam int OUT_W     = 20;
  localparam int SUM_W     = 40;
  localparam int SQ_W      = 60;
  localparam int EWMA_FRAC = 4;

  localparam logic [2:0] ST_NONE      = 3'd0;
  localparam logic [2:0] ST_SUCCESS   = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_CORRUPTED = 3'd3;
  localparam logic [2:0] ST_ERROR     = 3'd4;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [2:0]        status;
    logic [OUT_W-1:0]  rtt_us;
  } prs_in_t;

  typedef struct packed {
    logic [OUT_W-1:0]  sent;
    logic [OUT_W-1:0]  received;
    logic [OUT_W-1:0]  duplicates;
    logic [OUT_W-1:0]  corrupted;
    logic [OUT_W-1:0]  errors;
    logic [6:0]        loss_percent;
    logic [OUT_W-1:0]  rtt_min;
    logic [OUT_W-1:0]  rtt_avg;
    logic [OUT_W-1:0]  rtt_max;
    logic [OUT_W-1:0]  rtt_mdev;
    logic [OUT_W-1:0]  rtt_ewma;
    logic              have_rtt;
  } prs_out_t;

  // Clamp a wide value to the width of a result field.
  function automatic logic [OUT_W-1:0] sat_out(input logic [63:0] v);
    logic [OUT_W-1:0] r;
    r = (v > 64'((64'd1 << OUT_W) - 64'd1)) ? '1 : v[OUT_W-1:0];
    return r;
  endfunction

endpackage

### hdl/ping_rtt_statistics.sv
// Record words with a sample go through accept, a sum update and one
// reciprocal multiply that divides the moving-average numerator by ten.
// Other record words are finished in the accept step.
// Report words run the shared unit, one bit per step, through the average,
// two products, the variance quotient, the square root and the loss percent
// (RTT steps skipped without samples), then wait for a free output register.
// One word at a time; a finished report waits in the output register.
// Reset is synchronous and clears all statistics.
// ----------------------------------------------------------------------------
// ping_rtt_statistics
// Probe counters and RTT min/avg/max/mdev/ewma; the report arithmetic runs
// on one shift-add/subtract unit under a small sequencer.
// ----------------------------------------------------------------------------
module ping_rtt_statistics
  import prs_pkg::*;
#(
  parameter int RTT_BITS   = 20,
  parameter int COUNT_BITS = 20
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  prs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output prs_out_t out_data
);

  localparam int RW = RTT_BITS;
  localparam int CW = COUNT_BITS;
  localparam int EW = RTT_BITS + EWMA_FRAC;

  // Multiplying by this and dropping 35 bits divides any 32-bit value by ten.
  localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SAMP = 4'd1;
  localparam logic [3:0] S_EDIV = 4'd2;
  localparam logic [3:0] S_AVG  = 4'd3;
  localparam logic [3:0] S_MUL1 = 4'd4;
  localparam logic [3:0] S_MUL2 = 4'd5;
  localparam logic [3:0] S_DIFF = 4'd6;
  localparam logic [3:0] S_VDIV = 4'd7;
  localparam logic [3:0] S_SQRT = 4'd8;
  localparam logic [3:0] S_LSET = 4'd9;
  localparam logic [3:0] S_LOSS = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
    logic [CW-1:0] r;
    r = (&c) ? c : c + 1'b1;
    return r;
  endfunction

  logic [3:0]      state_r, state_nxt;
  logic [CW-1:0]   sent_r, sent_nxt, succ_r, succ_nxt, dup_r, dup_nxt;
  logic [CW-1:0]   corr_r, corr_nxt, err_r, err_nxt;
  logic [RW-1:0]   low_r, low_nxt, high_r, high_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SQ_W-1:0] sqsum_r, sqsum_nxt;
  logic [EW-1:0]   ewma_r, ewma_nxt;

  logic [RW-1:0]   rtt_r, rtt_nxt;
  logic [2*RW-1:0] sq_r, sq_nxt;
  logic            insum_r, insum_nxt;
  logic [CW:0]     n_r, n_nxt;
  logic [2*CW+1:0] nn_r, nn_nxt;

  logic [7:0]      cnt_r, cnt_nxt;
  logic [63:0]     a_r, a_nxt;
  logic [127:0]    b_r, b_nxt;
  logic [127:0]    acc_r, acc_nxt;
  logic [64:0]     rem_r, rem_nxt;
  logic [127:0]    p1_r, p1_nxt;

  logic [OUT_W-1:0] avg_r, avg_nxt, mdev_r, mdev_nxt;
  logic [6:0]      loss_r, loss_nxt;
  logic            out_valid_r, out_valid_nxt;
  prs_out_t        out_r, out_nxt;

  // Shared datapath: one compare/subtract for divide and root steps,
  // one shift-add for multiply steps.
  logic [64:0]     sub_x, sub_y, sub_d;
  logic            sub_ge;
  logic [127:0]    mul_acc;
  logic [127:0]    div_b, sqrt_b, mul_b;
  logic [64:0]     step_rem;
  logic            last;

  logic [31:0]     rtt32, rmax32, rtt_sel;
  logic [RW-1:0]   rtt_v;
  logic [SUM_W:0]  sum_add;
  logic [SQ_W:0]   sq_add;
  logic [CW:0]     n_in;
  logic [63:0]     q_var;
  logic [31:0]     root;
  logic [CW-1:0]   lost;
  logic [31:0]     ewma_num;
  logic [63:0]     ediv_prod;

  always_comb begin
    if (state_r == S_SQRT) begin
      sub_x = {rem_r[62:0], b_r[127:126]};
      sub_y = {31'b0, acc_r[31:0], 2'b01};
    end else begin
      sub_x = {rem_r[63:0], b_r[127]};
      sub_y = {1'b0, a_r};
    end
    sub_ge   = sub_x >= sub_y;
    sub_d    = sub_x - sub_y;
    step_rem = sub_ge ? sub_d : sub_x;
    div_b    = {b_r[126:0], sub_ge};
    sqrt_b   = {b_r[125:0], 2'b00};
    mul_b    = {b_r[126:0], 1'b0};
    mul_acc  = {acc_r[126:0], 1'b0} + (b_r[127] ? {64'b0, a_r} : 128'b0);
    last     = (cnt_r == 8'd1);
  end

  always_comb begin
    rtt32   = 32'(in_data.rtt_us);
    rmax32  = 32'((33'd1 << RW) - 33'd1);
    rtt_sel = (rtt32 > rmax32) ? rmax32 : rtt32;
    rtt_v   = rtt_sel[RW-1:0];
    sum_add = {1'b0, sum_r} + {{(SUM_W+1-RW){1'b0}}, rtt_r};
    sq_add  = {1'b0, sqsum_r} + {{(SQ_W+1-2*RW){1'b0}}, sq_r};
    n_in    = {1'b0, succ_r} + {1'b0, dup_r};
    q_var   = (|div_b[127:64]) ? '1 : div_b[63:0];
    root    = {acc_r[30:0], sub_ge};
    lost    = sent_r - succ_r;
    // Numerator of 0.9*old + 0.1*new with rounding, over ten.
    ewma_num  = 32'((64'(ewma_r) << 3) + 64'(ewma_r) + (64'(rtt_r) << EWMA_FRAC)
                    + 64'd5);
    ediv_prod = a_r[31:0] * DIV10_MAGIC;
  end

  always_comb begin
    state_nxt = state_r;
    sent_nxt = sent_r; succ_nxt = succ_r; dup_nxt = dup_r;
    corr_nxt = corr_r; err_nxt = err_r;
    low_nxt = low_r; high_nxt = high_r;
    sum_nxt = sum_r; sqsum_nxt = sqsum_r; ewma_nxt = ewma_r;
    rtt_nxt = rtt_r; sq_nxt = sq_r; insum_nxt = insum_r;
    n_nxt = n_r; nn_nxt = nn_r;
    cnt_nxt = cnt_r; a_nxt = a_r; b_nxt = b_r; acc_nxt = acc_r; rem_nxt = rem_r;
    p1_nxt = p1_r; avg_nxt = avg_r; mdev_nxt = mdev_r; loss_nxt = loss_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r & ~out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.kind == KIND_RECORD) begin
            if (in_data.status == ST_SUCCESS || in_data.status == ST_DUPLICATE) begin
              rtt_nxt = rtt_v;
              sq_nxt  = rtt_v * rtt_v;
              if (rtt_v < low_r)  low_nxt  = rtt_v;
              if (rtt_v > high_r) high_nxt = rtt_v;
              state_nxt = S_SAMP;
            end
            unique case (in_data.status)
              ST_NONE: sent_nxt = sat_inc(sent_r);
              ST_SUCCESS: begin
                sent_nxt  = sat_inc(sent_r);
                succ_nxt  = sat_inc(succ_r);
                insum_nxt = ~(&succ_r);
              end
              ST_DUPLICATE: begin
                dup_nxt   = sat_inc(dup_r);
                insum_nxt = ~(&dup_r);
              end
              ST_CORRUPTED: begin
                sent_nxt = sat_inc(sent_r);
                corr_nxt = sat_inc(corr_r);
              end
              ST_ERROR: begin
                sent_nxt = sat_inc(sent_r);
                err_nxt  = sat_inc(err_r);
              end
              default: ;
            endcase
          end else begin
            n_nxt  = n_in;
            nn_nxt = n_in * n_in;
            if (n_in == '0) begin
              avg_nxt   = '0;
              mdev_nxt  = '0;
              state_nxt = S_LSET;
            end else begin
              b_nxt     = {64'(sum_r), 64'b0};
              a_nxt     = 64'(n_in);
              rem_nxt   = '0;
              cnt_nxt   = 8'd64;
              state_nxt = S_AVG;
            end
          end
        end
      end
      S_SAMP: begin
        if (insum_r) begin
          sum_nxt   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
          sqsum_nxt = sq_add[SQ_W] ? '1 : sq_add[SQ_W-1:0];
        end
        a_nxt     = 64'(ewma_num);
        state_nxt = S_EDIV;
      end
      S_EDIV: begin
        ewma_nxt  = ediv_prod[EW+34:35];
        state_nxt = S_IDLE;
      end
      S_AVG: begin
        rem_nxt = step_rem; b_nxt = div_b; cnt_nxt = cnt_r - 8'd1;
        if (last) begin
          avg_nxt   = sat_out(div_b[63:0]);
          a_nxt     = 64'(sqsum_r);
          b_nxt     = {64'(n_r), 64'b0};
          acc_nxt   = '0;
          cnt_nxt   = 8'd64;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        acc_nxt = mul_acc; b_nxt = mul_b; cnt_nxt = cnt_r - 8'd1;
        if (last) begin
          p1_nxt    = mul_acc;
          a_nxt     = 64'(sum_r);
          b_nxt     = {64'(sum_r), 64'b0};
          acc_nxt   = '0;
          cnt_nxt   = 8'd64;
          state_nxt = S_MUL2;
        end
      end
      S_MUL2: begin
        acc_nxt = mul_acc; b_nxt = mul_b; cnt_nxt = cnt_r - 8'd1;
        if (last) state_nxt = S_DIFF;
      end
      S_DIFF: begin
        if (p1_r >= acc_r) begin
          b_nxt     = p1_r - acc_r;
          a_nxt     = 64'(nn_r);
          rem_nxt   = '0;
          cnt_nxt   = 8'd128;
          state_nxt = S_VDIV;
        end else begin
          mdev_nxt  = '0;
          state_nxt = S_LSET;
        end
      end
      S_VDIV: begin
        rem_nxt = step_rem; b_nxt = div_b; cnt_nxt = cnt_r - 8'd1;
        if (last) begin
          b_nxt     = {q_var, 64'b0};
          rem_nxt   = '0;
          acc_nxt   = '0;
          cnt_nxt   = 8'd32;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        rem_nxt = step_rem; b_nxt = sqrt_b; cnt_nxt = cnt_r - 8'd1;
        acc_nxt = {96'b0, root};
        if (last) begin
          mdev_nxt  = sat_out(64'(root));
          state_nxt = S_LSET;
        end
      end
      S_LSET: begin
        if (sent_r != '0 && succ_r <= sent_r) begin
          b_nxt     = {64'(lost) * 64'd100, 64'b0};
          a_nxt     = 64'(sent_r);
          rem_nxt   = '0;
          cnt_nxt   = 8'd64;
          state_nxt = S_LOSS;
        end else begin
          loss_nxt  = '0;
          state_nxt = S_FIN;
        end
      end
      S_LOSS: begin
        rem_nxt = step_rem; b_nxt = div_b; cnt_nxt = cnt_r - 8'd1;
        if (last) begin
          loss_nxt  = div_b[6:0];
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.sent         = sat_out(64'(sent_r));
          out_nxt.received     = sat_out(64'(succ_r));
          out_nxt.duplicates   = sat_out(64'(dup_r));
          out_nxt.corrupted    = sat_out(64'(corr_r));
          out_nxt.errors       = sat_out(64'(err_r));
          out_nxt.loss_percent = loss_r;
          out_nxt.rtt_avg      = avg_r;
          out_nxt.rtt_mdev     = mdev_r;
          out_nxt.have_rtt     = (succ_r != '0);
          if (n_r != '0) begin
            out_nxt.rtt_min  = sat_out(64'(low_r));
            out_nxt.rtt_max  = sat_out(64'(high_r));
            out_nxt.rtt_ewma = sat_out((64'(ewma_r) + 64'd8) >> EWMA_FRAC);
          end else begin
            out_nxt.rtt_min  = '0;
            out_nxt.rtt_max  = '0;
            out_nxt.rtt_ewma = '0;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sent_r      <= '0;
      succ_r      <= '0;
      dup_r       <= '0;
      corr_r      <= '0;
      err_r       <= '0;
      low_r       <= '1;
      high_r      <= '0;
      sum_r       <= '0;
      sqsum_r     <= '0;
      ewma_r      <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sent_r      <= sent_nxt;
      succ_r      <= succ_nxt;
      dup_r       <= dup_nxt;
      corr_r      <= corr_nxt;
      err_r       <= err_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      sum_r       <= sum_nxt;
      sqsum_r     <= sqsum_nxt;
      ewma_r      <= ewma_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rtt_r   <= rtt_nxt;
    sq_r    <= sq_nxt;
    insum_r <= insum_nxt;
    n_r     <= n_nxt;
    nn_r    <= nn_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    acc_r   <= acc_nxt;
    rem_r   <= rem_nxt;
    p1_r    <= p1_nxt;
    avg_r   <= avg_nxt;
    mdev_r  <= mdev_nxt;
    loss_r  <= loss_nxt;
    out_r   <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### hdl/prs_checker.sv
// ----------------------------------------------------------------------------
// prs_checker
// Port-level checks for the RTT statistics block, bound to the top level.
// ----------------------------------------------------------------------------
module prs_checker
  import prs_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input prs_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input prs_out_t out_data
);

  // No result word may appear right after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  a_loss_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.loss_percent <= 7'd100)
    else $error("loss percent above 100");

  a_have_rtt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.have_rtt == (out_data.received != '0))
    else $error("have_rtt disagrees with received count");

  // Without any sample the RTT min, max and EWMA figures read zero.
  a_no_samples: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.received == '0 && out_data.duplicates == '0 |->
      out_data.rtt_min == '0 && out_data.rtt_max == '0 && out_data.rtt_ewma == '0)
    else $error("RTT figures nonzero without samples");

endmodule

bind ping_rtt_statistics prs_checker u_prs_checker (.*);
